@@ hdl/tts_pkg.sv @@
// Shared definitions for the tick task scheduler: request codes, default sizes and
// the run-now reload constant. No dependencies.
`timescale 1ns / 1ps

package tts_pkg;

   // Default sizes handed to the top level parameters.
   localparam int TASK_COUNT_DEF  = 8;
   localparam int PERIOD_BITS_DEF = 16;

   // Field widths of a request and of a result.
   localparam int REQ_TYPE_W = 3;
   localparam int TASK_IDX_W = 3;
   localparam int VALUE_W    = 16;

   // Request codes. Codes 5 to 7 are ignored.
   localparam logic [REQ_TYPE_W-1:0] OP_TICK       = 3'd0;
   localparam logic [REQ_TYPE_W-1:0] OP_SET_PERIOD = 3'd1;
   localparam logic [REQ_TYPE_W-1:0] OP_SET_ENABLE = 3'd2;
   localparam logic [REQ_TYPE_W-1:0] OP_RUN_NOW    = 3'd3;
   localparam logic [REQ_TYPE_W-1:0] OP_RESTART    = 3'd4;

   // Countdown loaded by run now when the period is one tick.
   localparam int RUN_NOW_SHORT = 2;

   // Width of an index into n entries, at least one bit.
   function automatic int idx_width(input int n);
      int w;
      begin
         w = (n > 1) ? $clog2(n) : 1;
         return w;
      end
   endfunction

endpackage

@@ hdl/tts_cell.sv @@
// One cell of the task ring: period, countdown and enable bit of one task.
// Loads its neighbor's record on a shift. Uses tts_pkg.
`timescale 1ns / 1ps

module tts_cell #(
   parameter int PERIOD_BITS = tts_pkg::PERIOD_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   shift,
   input  logic [PERIOD_BITS-1:0] per_in,
   input  logic [PERIOD_BITS-1:0] cnt_in,
   input  logic                   en_in,
   input  logic [PERIOD_BITS-1:0] key,
   output logic [PERIOD_BITS-1:0] per_out,
   output logic [PERIOD_BITS-1:0] cnt_out,
   output logic                   en_out,
   output logic                   match
);
   import tts_pkg::*;

   logic [PERIOD_BITS-1:0] per_ff;
   logic [PERIOD_BITS-1:0] cnt_ff;
   logic                   en_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         per_ff <= '0;
         cnt_ff <= '0;
         en_ff  <= 1'b0;
      end else if (shift) begin
         per_ff <= per_in;
         cnt_ff <= cnt_in;
         en_ff  <= en_in;
      end
   end

   // The controller broadcasts the head period; each cell reports whether it shares it.
   assign match   = (per_ff == key);
   assign per_out = per_ff;
   assign cnt_out = cnt_ff;
   assign en_out  = en_ff;

endmodule

@@ hdl/tts_div.sv @@
// Restoring divider, one quotient bit per cycle, for the restart spread.
// Depends on tts_pkg for its parameter defaults.
`timescale 1ns / 1ps

module tts_div #(
   parameter int DIVIDEND_W = tts_pkg::PERIOD_BITS_DEF,
   parameter int DIVISOR_W  = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);
   import tts_pkg::*;

   localparam int STEP_W = $clog2(DIVIDEND_W + 1);

   logic                  active_ff;
   logic                  done_ff;
   logic [STEP_W-1:0]     step_ff;
   logic [DIVIDEND_W-1:0] quo_ff;
   logic [DIVISOR_W-1:0]  rem_ff;

   logic [DIVISOR_W:0]    trial;
   logic                  fits;
   logic [DIVISOR_W-1:0]  rem_in;

   always_comb begin
      trial  = {rem_ff, quo_ff[DIVIDEND_W-1]};
      fits   = (trial >= {1'b0, divisor});
      rem_in = fits ? DIVISOR_W'(trial - {1'b0, divisor}) : DIVISOR_W'(trial);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         step_ff   <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            active_ff <= 1'b1;
            step_ff   <= '0;
         end else if (active_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_W'(DIVIDEND_W - 1)) begin
               active_ff <= 1'b0;
               done_ff   <= 1'b1;
            end
         end
      end
   end

   // The dividend shifts out at the top while quotient bits enter at the bottom.
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
      end else if (active_ff) begin
         quo_ff <= {quo_ff[DIVIDEND_W-2:0], fits};
         rem_ff <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ hdl/tick_task_scheduler_core.sv @@
// Top level of the tick task scheduler: controller, task ring and divider.
// Depends on tts_pkg, tts_cell and tts_div.
`timescale 1ns / 1ps

// A request is taken at a clock edge where start is high and busy is low, and
// busy stays high until its result is out. Every request yields exactly one result
// beat: rsp_valid is high for a single cycle with rsp_ran and rsp_ran_task, and the
// receiver cannot hold it off, so it must take the beat in that cycle. The tasks
// live in a ring of TASK_COUNT cells that rotates one place per cycle, unless a
// restart holds it, past a single processing point, so a tick, set period, set
// enable, run now or ignored request visits every task once, and the registered
// result beat follows the last task. A restart additionally stops the ring at each
// task with a nonzero period, counts the tasks that share its period, divides the
// period by that count one bit per cycle and multiplies by the rank. The next
// request may be issued in the same cycle as the result beat.

module tick_task_scheduler_core #(
   parameter int TASK_COUNT  = tts_pkg::TASK_COUNT_DEF,
   parameter int PERIOD_BITS = tts_pkg::PERIOD_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [tts_pkg::REQ_TYPE_W-1:0] req_type,
   input  logic [tts_pkg::TASK_IDX_W-1:0] req_task_index,
   input  logic [tts_pkg::VALUE_W-1:0]    req_value,
   output logic                           rsp_valid,
   output logic                           rsp_ran,
   output logic [tts_pkg::TASK_IDX_W-1:0] rsp_ran_task
);
   import tts_pkg::*;

   localparam int IDX_W  = idx_width(TASK_COUNT);
   localparam int CNT_W  = $clog2(TASK_COUNT + 1);
   localparam int PROD_W = PERIOD_BITS + CNT_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COUNT,
      ST_DIVGO,
      ST_DIV,
      ST_MUL,
      ST_WB
   } state_type;

   // Controller registers.
   state_type              state_ff;
   logic [IDX_W-1:0]       head_ff;
   logic [IDX_W-1:0]       probe_ff;
   logic [REQ_TYPE_W-1:0]  op_ff;
   logic [TASK_IDX_W-1:0]  idx_ff;
   logic [VALUE_W-1:0]     val_ff;
   logic                   ran_ff;
   logic [IDX_W-1:0]       who_ff;
   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       rank_ff;
   logic [PROD_W-1:0]      prod_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_ran_ff;
   logic [TASK_IDX_W-1:0]  rsp_ran_task_ff;

   // Ring wiring.
   logic [PERIOD_BITS-1:0] per_w [TASK_COUNT];
   logic [PERIOD_BITS-1:0] cnt_w [TASK_COUNT];
   logic                   en_w  [TASK_COUNT];
   logic [TASK_COUNT-1:0]  match_w;
   logic [TASK_COUNT-1:0]  earlier_w;
   logic                   ring_shift;

   // The record that re-enters the ring at its tail after the head is processed.
   logic [PERIOD_BITS-1:0] ring_per_in;
   logic [PERIOD_BITS-1:0] ring_cnt_in;
   logic                   ring_en_in;
   logic                   hit_in;

   logic [PERIOD_BITS-1:0] head_per;
   logic [PERIOD_BITS-1:0] head_cnt;
   logic                   head_en;
   logic                   idx_hit;
   logic                   last_head;
   logic                   restart_live;
   logic [31:0]            val_ext;
   logic [PERIOD_BITS-1:0] new_per;
   logic [PERIOD_BITS-1:0] tick_cnt;
   logic [31:0]            who_ext;

   logic                   div_done;
   logic [PERIOD_BITS-1:0] div_quo;

   assign head_per = per_w[0];
   assign head_cnt = cnt_w[0];
   assign head_en  = en_w[0];

   // Task at the head is head_ff; an out of range index never matches it.
   assign idx_hit      = (32'(idx_ff) == 32'(head_ff));
   assign last_head    = (head_ff == IDX_W'(TASK_COUNT - 1));
   assign restart_live = (op_ff == OP_RESTART) && (head_per != '0);
   assign val_ext      = 32'(val_ff);
   assign new_per      = val_ext[PERIOD_BITS-1:0];
   assign who_ext      = 32'(who_ff);

   // Head processing for one task per cycle, unless a restart holds the ring.
   always_comb begin
      ring_per_in = head_per;
      ring_cnt_in = head_cnt;
      ring_en_in  = head_en;
      hit_in      = 1'b0;
      tick_cnt    = (head_cnt != '0) ? head_cnt - 1'b1 : head_cnt;
      if (state_ff == ST_WB) begin
         // Restart spread: a zero offset means a full period.
         ring_cnt_in = (prod_ff == '0) ? head_per : prod_ff[PERIOD_BITS-1:0];
      end else begin
         case (op_ff)
            OP_TICK: begin
               if (head_per != '0) begin
                  ring_cnt_in = tick_cnt;
                  // Only the first expired enabled task runs; later ones wait at zero.
                  if (tick_cnt == '0 && !ran_ff) begin
                     ring_cnt_in = head_per;
                     hit_in      = head_en;
                  end
               end
            end
            OP_SET_PERIOD: begin
               if (idx_hit) begin
                  ring_per_in = new_per;
                  if (new_per != '0 && head_cnt > new_per) begin
                     ring_cnt_in = new_per;
                  end
               end
            end
            OP_SET_ENABLE: begin
               if (idx_hit) begin
                  ring_en_in = val_ff[0];
               end
            end
            OP_RUN_NOW: begin
               if (idx_hit && head_en && head_per != '0) begin
                  hit_in      = 1'b1;
                  ring_cnt_in = (head_per == PERIOD_BITS'(1)) ?
                                PERIOD_BITS'(RUN_NOW_SHORT) : head_per;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign ring_shift = ((state_ff == ST_SCAN) && !restart_live) || (state_ff == ST_WB);

   // The ring: cell i takes the record of cell i+1; the tail takes the processed head.
   for (genvar c = 0; c < TASK_COUNT; c++) begin : g_cell
      if (c == TASK_COUNT - 1) begin : g_tail
         tts_cell #(.PERIOD_BITS(PERIOD_BITS)) u_cell (
            .clock   (clock),
            .reset   (reset),
            .shift   (ring_shift),
            .per_in  (ring_per_in),
            .cnt_in  (ring_cnt_in),
            .en_in   (ring_en_in),
            .key     (head_per),
            .per_out (per_w[c]),
            .cnt_out (cnt_w[c]),
            .en_out  (en_w[c]),
            .match   (match_w[c])
         );
      end else begin : g_body
         tts_cell #(.PERIOD_BITS(PERIOD_BITS)) u_cell (
            .clock   (clock),
            .reset   (reset),
            .shift   (ring_shift),
            .per_in  (per_w[c+1]),
            .cnt_in  (cnt_w[c+1]),
            .en_in   (en_w[c+1]),
            .key     (head_per),
            .per_out (per_w[c]),
            .cnt_out (cnt_w[c]),
            .en_out  (en_w[c]),
            .match   (match_w[c])
         );
      end
      // Tasks with a lower index than the head sit at the far end of the ring.
      assign earlier_w[c] = ((32'(c) + 32'(head_ff)) >= 32'(TASK_COUNT));
   end

   // Period divided by the number of tasks that share it.
   tts_div #(
      .DIVIDEND_W (PERIOD_BITS),
      .DIVISOR_W  (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == ST_DIVGO),
      .dividend (head_per),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Controller state and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         head_ff         <= '0;
         probe_ff        <= '0;
         ran_ff          <= 1'b0;
         who_ff          <= '0;
         count_ff        <= '0;
         rank_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
         rsp_ran_ff      <= 1'b0;
         rsp_ran_task_ff <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  op_ff    <= req_type;
                  idx_ff   <= req_task_index;
                  val_ff   <= req_value;
                  ran_ff   <= 1'b0;
                  who_ff   <= '0;
                  head_ff  <= '0;
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (restart_live) begin
                  count_ff <= '0;
                  rank_ff  <= '0;
                  probe_ff <= '0;
                  state_ff <= ST_COUNT;
               end else begin
                  if (hit_in) begin
                     ran_ff <= 1'b1;
                     who_ff <= head_ff;
                  end
                  if (last_head) begin
                     head_ff         <= '0;
                     state_ff        <= ST_IDLE;
                     rsp_valid_ff    <= 1'b1;
                     rsp_ran_ff      <= ran_ff || hit_in;
                     rsp_ran_task_ff <= hit_in ? TASK_IDX_W'(32'(head_ff)) :
                                        (ran_ff ? who_ext[TASK_IDX_W-1:0] : '0);
                  end else begin
                     head_ff <= head_ff + 1'b1;
                  end
               end
            end
            ST_COUNT: begin
               // One ring position per cycle: tasks sharing the head period, and those before it.
               count_ff <= count_ff + CNT_W'(match_w[probe_ff]);
               rank_ff  <= rank_ff + CNT_W'(match_w[probe_ff] && earlier_w[probe_ff]);
               if (probe_ff == IDX_W'(TASK_COUNT - 1)) begin
                  state_ff <= ST_DIVGO;
               end else begin
                  probe_ff <= probe_ff + 1'b1;
               end
            end
            ST_DIVGO: begin
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (div_done) begin
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               prod_ff  <= PROD_W'(rank_ff) * PROD_W'(div_quo);
               state_ff <= ST_WB;
            end
            ST_WB: begin
               // Restart never runs a task, so the result is always "none ran".
               if (last_head) begin
                  head_ff         <= '0;
                  state_ff        <= ST_IDLE;
                  rsp_valid_ff    <= 1'b1;
                  rsp_ran_ff      <= 1'b0;
                  rsp_ran_task_ff <= '0;
               end else begin
                  head_ff  <= head_ff + 1'b1;
                  state_ff <= ST_SCAN;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy         = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_ran      = rsp_ran_ff;
   assign rsp_ran_task = rsp_ran_task_ff;

endmodule
